@@ design/mma_pkg.sv @@
// Package for the matrix multiply-add core: sizes, codes, shared types and
// address helpers. No dependencies; mma_mac and the top level use it.
`timescale 1ns / 1ps
`default_nettype none

package mma_pkg;

  // Largest matrix dimension that the stores hold.
  localparam int unsigned MaxDim = 64;

  localparam int unsigned IdxW    = $clog2(MaxDim);
  localparam int unsigned DimW    = $clog2(MaxDim + 1);
  localparam int unsigned Depth   = MaxDim * MaxDim;
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam int unsigned DataW   = 32;
  localparam int unsigned CfgW    = 7;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [DimW-1:0]  dim_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [DataW-1:0] data_t;
  typedef logic [CfgW-1:0]  cfg_t;

  localparam cfg_t DimRst = 7'd64;

  typedef enum logic [1:0] {
    OpWriteA   = 2'd0,
    OpWriteB   = 2'd1,
    OpReadProd = 2'd2,
    OpReadSum  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StRange = 2'd1,
    StShape = 2'd2
  } stat_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRowsA    = 2'd0,
    CfgInnerDim = 2'd1,
    CfgColsB    = 2'd2
  } cfg_idx_e;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clr;  // zero the accumulator
    logic vld;  // store read data is a valid operand pair
  } mac_ctl_t;

  // Clamp a programmed dimension to the store size.
  function automatic dim_t eff_dim(cfg_t v);
    dim_t d;
    if (32'(v) > MaxDim) begin
      d = DimW'(MaxDim);
    end else begin
      d = DimW'(v);
    end
    return d;
  endfunction

  // Row-major entry address.
  function automatic addr_t addr_of(idx_t r, idx_t c);
    return addr_t'(r) * addr_t'(MaxDim) + addr_t'(c);
  endfunction

endpackage

`default_nettype wire

@@ design/mma_if.sv @@
// Valid/ready channels of the matrix multiply-add core: request items in,
// result items out. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface mma_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [5:0]         row;
  logic [5:0]         col;
  logic signed [31:0] value;

  modport source (output valid, output opcode, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input opcode, input row, input col, input value,
                  output ready);
endinterface

interface mma_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result;
  logic [1:0]         status;

  modport source (output valid, output result, output status, input ready);
  modport sink   (input valid, input result, input status, output ready);
endinterface

`default_nettype wire

@@ design/mma_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mma_ram #(
  parameter  int unsigned Depth = 4096,
  parameter  int unsigned Width = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ design/mma_mac.sv @@
// Multiply-accumulate unit: registered 32x32 product, then a 32-bit wrapping
// accumulate. Depends on mma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mma_mac (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mma_pkg::mac_ctl_t ctl_i,
  input  wire mma_pkg::data_t    a_i,
  input  wire mma_pkg::data_t    b_i,
  output mma_pkg::data_t         acc_o,
  output logic                   busy_o
);

  mma_pkg::data_t prod_q;
  mma_pkg::data_t acc_q;
  logic           prod_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctl_i.vld;
    end
  end

  // Low half of the product is the same for signed and unsigned operands.
  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      prod_q <= a_i * b_i;
    end
    if (ctl_i.clr) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + prod_q;
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = prod_vld_q;

endmodule

`default_nettype wire

@@ design/matrix_multiply_add_core.sv @@
// Top level of the matrix multiply-add core: sequencer, dimension registers,
// A and B stores, output register. Depends on mma_pkg, mma_if, mma_ram, mma_mac.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake      Payload
// req_i     in   valid/ready    opcode, row, col, value
// rsp_o     out  valid/ready    result, status
// cfg       in   cfg_we_i       cfg_idx_i, cfg_data_i (rows_a, inner_dim, cols_b)
//
// One item is in flight at a time. A write goes into its store from idle. A sum
// read registers both store words, then their sum, then the output register. A
// product read streams inner_dim pairs out of the two stores, one per cycle (one
// read port each), through the MAC; this store walk sets the rate.
// Reset clears control state and sets all dimensions to 64; the stores are not
// cleared. A stalled result sits in the output register while writes and the
// next item go on; a finished read waits in a hold state only if that register
// is still full.

module matrix_multiply_add_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [mma_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [mma_pkg::CfgW-1:0]        cfg_data_i,
  mma_req_if.sink                              req_i,
  mma_rsp_if.source                            rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_DRAIN,
    S_SUM,
    S_FIN
  } state_e;

  // Dimension registers.
  mma_pkg::cfg_t rows_a_q, inner_dim_q, cols_b_q;
  mma_pkg::dim_t ra, ki, cb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= mma_pkg::DimRst;
      inner_dim_q <= mma_pkg::DimRst;
      cols_b_q    <= mma_pkg::DimRst;
    end else if (cfg_we_i) begin
      unique case (mma_pkg::cfg_idx_e'(cfg_idx_i))
        mma_pkg::CfgRowsA:    rows_a_q    <= cfg_data_i;
        mma_pkg::CfgInnerDim: inner_dim_q <= cfg_data_i;
        mma_pkg::CfgColsB:    cols_b_q    <= cfg_data_i;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  assign ra = mma_pkg::eff_dim(rows_a_q);
  assign ki = mma_pkg::eff_dim(inner_dim_q);
  assign cb = mma_pkg::eff_dim(cols_b_q);

  // Sequencer state.
  state_e            state_q, state_d;
  mma_pkg::idx_t     row_q, row_d, col_q, col_d;
  mma_pkg::dim_t     k_q, k_d;
  logic              rd_vld_q, rd_vld_d;
  mma_pkg::data_t    res_q, res_d;
  mma_pkg::stat_e    stat_q, stat_d;
  logic              out_vld_q, out_vld_d;
  mma_pkg::data_t    out_res_q, out_res_d;
  mma_pkg::stat_e    out_stat_q, out_stat_d;

  // Store and MAC hookup.
  logic              wa_en, wb_en;
  mma_pkg::addr_t    waddr, ra_addr, rb_addr;
  mma_pkg::data_t    a_rdata, b_rdata;
  mma_pkg::mac_ctl_t mac_ctl;
  mma_pkg::data_t    acc;
  logic              mac_busy;

  logic              in_acc;
  mma_pkg::idx_t     in_row, in_col;

  assign req_i.ready = (state_q == S_IDLE);
  assign in_acc      = req_i.valid && req_i.ready;
  assign in_row      = mma_pkg::IdxW'(req_i.row);
  assign in_col      = mma_pkg::IdxW'(req_i.col);
  assign waddr       = mma_pkg::addr_of(in_row, in_col);

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    k_d        = k_q;
    rd_vld_d   = 1'b0;
    res_d      = res_q;
    stat_d     = stat_q;
    out_vld_d  = out_vld_q;
    out_res_d  = out_res_q;
    out_stat_d = out_stat_q;
    wa_en      = 1'b0;
    wb_en      = 1'b0;
    mac_ctl    = '{clr: 1'b0, vld: rd_vld_q};
    // Idle reads address straight from the request: a sum needs (row, col).
    ra_addr    = waddr;
    rb_addr    = waddr;

    if (rsp_o.valid && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (mma_pkg::op_e'(req_i.opcode))
            mma_pkg::OpWriteA: begin
              wa_en = (req_i.row < ra) && (req_i.col < ki);
            end
            mma_pkg::OpWriteB: begin
              wb_en = (req_i.row < ki) && (req_i.col < cb);
            end
            mma_pkg::OpReadProd: begin
              if (!((req_i.row < ra) && (req_i.col < cb))) begin
                res_d   = '0;
                stat_d  = mma_pkg::StRange;
                state_d = S_FIN;
              end else if (ki == '0) begin
                // Empty inner dimension: the dot product is zero.
                res_d   = '0;
                stat_d  = mma_pkg::StOk;
                state_d = S_FIN;
              end else begin
                row_d       = in_row;
                col_d       = in_col;
                k_d         = '0;
                mac_ctl.clr = 1'b1;
                state_d     = S_PROD;
              end
            end
            mma_pkg::OpReadSum: begin
              if ((ra != ki) || (ki != cb)) begin
                res_d   = '0;
                stat_d  = mma_pkg::StShape;
                state_d = S_FIN;
              end else if ((req_i.row < ra) && (req_i.col < ki)) begin
                state_d = S_SUM;
              end else begin
                res_d   = '0;
                stat_d  = mma_pkg::StRange;
                state_d = S_FIN;
              end
            end
            default: ;
          endcase
        end
      end

      S_PROD: begin
        // Issue A(row, k) and B(k, col); data returns next cycle.
        ra_addr  = mma_pkg::addr_of(row_q, k_q[mma_pkg::IdxW-1:0]);
        rb_addr  = mma_pkg::addr_of(k_q[mma_pkg::IdxW-1:0], col_q);
        rd_vld_d = 1'b1;
        if (k_q + mma_pkg::DimW'(1) == ki) begin
          state_d = S_DRAIN;
        end else begin
          k_d = k_q + mma_pkg::DimW'(1);
        end
      end

      S_DRAIN: begin
        // Wait for the last read and product to land in the accumulator.
        if (!rd_vld_q && !mac_busy) begin
          res_d   = acc;
          stat_d  = mma_pkg::StOk;
          state_d = S_FIN;
        end
      end

      S_SUM: begin
        res_d   = a_rdata + b_rdata;
        stat_d  = mma_pkg::StOk;
        state_d = S_FIN;
      end

      S_FIN: begin
        // Hold the result until the output register is free.
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d  = 1'b1;
          out_res_d  = res_q;
          out_stat_d = stat_q;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rd_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      row_q      <= '0;
      col_q      <= '0;
      k_q        <= '0;
      res_q      <= '0;
      stat_q     <= mma_pkg::StOk;
      out_res_q  <= '0;
      out_stat_q <= mma_pkg::StOk;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= rd_vld_d;
      out_vld_q  <= out_vld_d;
      row_q      <= row_d;
      col_q      <= col_d;
      k_q        <= k_d;
      res_q      <= res_d;
      stat_q     <= stat_d;
      out_res_q  <= out_res_d;
      out_stat_q <= out_stat_d;
    end
  end

  assign rsp_o.valid  = out_vld_q;
  assign rsp_o.result = out_res_q;
  assign rsp_o.status = out_stat_q;

  // Writes land only from idle and reads follow later, so the stores need
  // no forwarding.
  mma_ram #(
    .Depth (mma_pkg::Depth),
    .Width (mma_pkg::DataW)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (wa_en),
    .waddr_i (waddr),
    .wdata_i (req_i.value),
    .raddr_i (ra_addr),
    .rdata_o (a_rdata)
  );

  mma_ram #(
    .Depth (mma_pkg::Depth),
    .Width (mma_pkg::DataW)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (wb_en),
    .waddr_i (waddr),
    .wdata_i (req_i.value),
    .raddr_i (rb_addr),
    .rdata_o (b_rdata)
  );

  mma_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (a_rdata),
    .b_i    (b_rdata),
    .acc_o  (acc),
    .busy_o (mac_busy)
  );

endmodule

`default_nettype wire
